// ----- design/hkt_pkg.sv -----
// ----------------------------------------------------------------------------
// hkt_pkg: shared types and constants of the hashed key take table
// Beat formats, result codes and the mixing constants of the bucket hash.
// ----------------------------------------------------------------------------
package hkt_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned ENTRY_W = 64;

  localparam int unsigned DEF_BUCKETS      = 256;
  localparam int unsigned DEF_WAYS         = 4;
  localparam int unsigned DEF_PAYLOAD_BITS = 64;

  // 64-bit finalizer: xor-shift, multiply, xor-shift, multiply, xor-shift.
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT = 33;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TAKE   = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_KEY  = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic               operation;
    logic [KEY_W-1:0]   key;
    logic [ENTRY_W-1:0] entry_in;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [ENTRY_W-1:0] entry_out;
  } out_t;

  // Outcome of one bucket update.
  typedef struct packed {
    status_e            status;
    logic [ENTRY_W-1:0] entry;
    logic               wr;
  } upd_t;

endpackage

// ----- design/hkt_ram.sv -----
// ----------------------------------------------------------------------------
// hkt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hkt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/hkt_hash.sv -----
// ----------------------------------------------------------------------------
// hkt_hash: bucket index of a key
// Multi-cycle 64-bit finalizer built from 32x32 partial products, followed
// by a reduction modulo the bucket count (a mask for powers of two, else a
// nibble-serial remainder).
// ----------------------------------------------------------------------------
module hkt_hash import hkt_pkg::*; #(
  parameter int unsigned BUCKETS = DEF_BUCKETS,
  localparam int unsigned BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [BW-1:0]    bucket_o
);

  localparam int unsigned TW   = BW + 4;
  localparam bit          POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  typedef enum logic [1:0] {H_IDLE, H_MUL, H_SUM, H_MOD} hstate_e;

  hstate_e     state_q, state_d;
  logic        round_q, round_d;
  logic [63:0] x_q, x_d;
  logic [63:0] pp_lo_q, pp_lo_d;
  logic [31:0] pp_a_q, pp_a_d;
  logic [31:0] pp_b_q, pp_b_d;
  logic [BW-1:0] r_q, r_d;
  logic [3:0]  nib_q, nib_d;
  logic        done_q, done_d;
  logic [BW-1:0] bucket_q, bucket_d;

  logic [63:0] c;
  logic [63:0] sum;
  logic [63:0] mixed;
  logic [BW-1:0] mod_next;

  // One remainder step: t is below sixteen times the bucket count.
  function automatic logic [BW-1:0] mod_step(input logic [TW-1:0] t);
    logic [TW-1:0] v;
    v = t;
    for (int k = 3; k >= 0; k--) begin
      if (v >= (TW'(BUCKETS) << k)) begin
        v = v - (TW'(BUCKETS) << k);
      end
    end
    return v[BW-1:0];
  endfunction

  always_comb begin
    c        = round_q ? MIX_C2 : MIX_C1;
    sum      = pp_lo_q + {pp_a_q + pp_b_q, 32'h0};
    mixed    = sum ^ (sum >> MIX_SHIFT);
    mod_next = mod_step({r_q, x_q[63:60]});

    state_d  = state_q;
    round_d  = round_q;
    x_d      = x_q;
    pp_lo_d  = pp_lo_q;
    pp_a_d   = pp_a_q;
    pp_b_d   = pp_b_q;
    r_d      = r_q;
    nib_d    = nib_q;
    done_d   = 1'b0;
    bucket_d = bucket_q;

    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          x_d     = key_i ^ (key_i >> MIX_SHIFT);
          round_d = 1'b0;
          state_d = H_MUL;
        end
      end
      H_MUL: begin
        pp_lo_d = 64'(x_q[31:0]) * 64'(c[31:0]);
        pp_a_d  = x_q[31:0] * c[63:32];
        pp_b_d  = x_q[63:32] * c[31:0];
        state_d = H_SUM;
      end
      H_SUM: begin
        x_d = mixed;
        if (!round_q) begin
          round_d = 1'b1;
          state_d = H_MUL;
        end else if (POW2) begin
          bucket_d = mixed[BW-1:0] & BW'(BUCKETS - 1);
          done_d   = 1'b1;
          state_d  = H_IDLE;
        end else begin
          r_d     = '0;
          nib_d   = '0;
          state_d = H_MOD;
        end
      end
      H_MOD: begin
        r_d   = mod_next;
        x_d   = x_q << 4;
        nib_d = nib_q + 4'd1;
        if (nib_q == 4'hf) begin
          bucket_d = mod_next;
          done_d   = 1'b1;
          state_d  = H_IDLE;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= H_IDLE;
      round_q  <= 1'b0;
      x_q      <= '0;
      pp_lo_q  <= '0;
      pp_a_q   <= '0;
      pp_b_q   <= '0;
      r_q      <= '0;
      nib_q    <= '0;
      done_q   <= 1'b0;
      bucket_q <= '0;
    end else begin
      state_q  <= state_d;
      round_q  <= round_d;
      x_q      <= x_d;
      pp_lo_q  <= pp_lo_d;
      pp_a_q   <= pp_a_d;
      pp_b_q   <= pp_b_d;
      r_q      <= r_d;
      nib_q    <= nib_d;
      done_q   <= done_d;
      bucket_q <= bucket_d;
    end
  end

  assign done_o   = done_q;
  assign bucket_o = bucket_q;

endmodule

// ----- design/hkt_bucket.sv -----
// ----------------------------------------------------------------------------
// hkt_bucket: update of one bucket row
// Looks up the key among the ways of a row and builds the row to write back
// together with the status and payload of the operation.
// ----------------------------------------------------------------------------
module hkt_bucket import hkt_pkg::*; #(
  parameter int unsigned WAYS         = DEF_WAYS,
  parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS,
  localparam int unsigned SLOT_W      = 1 + KEY_W + PAYLOAD_BITS,
  localparam int unsigned ROW_W       = WAYS * SLOT_W
) (
  input  logic [ROW_W-1:0]        row_i,
  input  logic                    op_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  output logic [ROW_W-1:0]        row_o,
  output upd_t                    upd_o
);

  localparam int unsigned WIW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic              hit_any, free_any;
  logic [WIW-1:0]    hit_idx, free_idx;
  logic [SLOT_W-1:0] slot, hit_slot;

  // Each slot is {valid, key, payload}; the lowest matching and the lowest
  // free way win.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      slot = row_i[w*SLOT_W +: SLOT_W];
      if (slot[SLOT_W-1] && (slot[PAYLOAD_BITS +: KEY_W] == key_i) && !hit_any) begin
        hit_any = 1'b1;
        hit_idx = WIW'(w);
      end
      if (!slot[SLOT_W-1] && !free_any) begin
        free_any = 1'b1;
        free_idx = WIW'(w);
      end
    end
    hit_slot = row_i[hit_idx*SLOT_W +: SLOT_W];

    row_o        = row_i;
    upd_o.status = ST_OK;
    upd_o.entry  = '0;
    upd_o.wr     = 1'b0;

    if (op_i == OP_INSERT) begin
      if (hit_any) begin
        upd_o.status = ST_PRESENT;
      end else if (free_any) begin
        row_o[free_idx*SLOT_W +: SLOT_W] = {1'b1, key_i, payload_i};
        upd_o.wr = 1'b1;
      end else begin
        upd_o.status = ST_FULL;
      end
    end else begin
      if (hit_any) begin
        row_o[hit_idx*SLOT_W + SLOT_W - 1] = 1'b0;
        upd_o.entry = ENTRY_W'(hit_slot[PAYLOAD_BITS-1:0]);
        upd_o.wr    = 1'b1;
      end else begin
        upd_o.status = ST_NOT_FOUND;
      end
    end
  end

endmodule

// ----- design/hashed_key_take_table.sv -----
// ----------------------------------------------------------------------------
// hashed_key_take_table: set-associative keyed table with insert and take
// Keys are hashed to a bucket; each bucket is one row of a RAM holding all
// of its ways, updated by read-modify-write.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Beat type | Handshake
//   --------+-----------+-----------+-------------------------
//   in      | input     | in_t      | in_valid_i / in_ready_o
//   out     | output    | out_t     | out_valid_o / out_ready_i
//
// Steps: a nonzero key passes through the hash multiply rounds, row read, row update and write, and
// the output register when BUCKETS is a power of two, and the input reopens when the result enters
// the output register; other bucket counts add the nibble-serial remainder. A zero key skips the
// hash and the RAM. Reset: the block clears one bucket row per cycle for BUCKETS cycles after
// rst_ni rises, with in_ready_o low. Stalls: a waiting result only holds the next item back once
// that item's own result is ready.
//
// The block works on one item at a time, so the read of a bucket always
// follows the write-back of the previous item and needs no forwarding.
// ----------------------------------------------------------------------------
module hashed_key_take_table import hkt_pkg::*; #(
  parameter int unsigned BUCKETS      = DEF_BUCKETS,
  parameter int unsigned WAYS         = DEF_WAYS,
  parameter int unsigned PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SLOT_W = 1 + KEY_W + PAYLOAD_BITS;
  localparam int unsigned ROW_W  = WAYS * SLOT_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_MOD, S_PUSH} state_e;

  state_e        state_q, state_d;
  logic [BW-1:0] clr_q, clr_d;
  in_t           req_q, req_d;
  logic [BW-1:0] bkt_q, bkt_d;
  out_t          res_q, res_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_data_q, out_data_d;

  logic             hash_start;
  logic             hash_done;
  logic [BW-1:0]    hash_bucket;
  logic             ram_we, ram_re;
  logic [BW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata, row_new;
  upd_t             upd;

  hkt_hash #(
    .BUCKETS(BUCKETS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (in_data_i.key),
    .done_o  (hash_done),
    .bucket_o(hash_bucket)
  );

  hkt_ram #(
    .WIDTH(ROW_W),
    .DEPTH(BUCKETS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(hash_bucket),
    .rdata_o(ram_rdata)
  );

  hkt_bucket #(
    .WAYS        (WAYS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_bucket (
    .row_i    (ram_rdata),
    .op_i     (req_q.operation),
    .key_i    (req_q.key),
    .payload_i(req_q.entry_in[PAYLOAD_BITS-1:0]),
    .row_o    (row_new),
    .upd_o    (upd)
  );

  // The clearing sweep and the row write-back share the RAM write port;
  // they never overlap because items are only taken after the sweep.
  always_comb begin
    ram_we    = (state_q == S_CLEAR) || ((state_q == S_MOD) && upd.wr);
    ram_waddr = (state_q == S_CLEAR) ? clr_q : bkt_q;
    ram_wdata = (state_q == S_CLEAR) ? '0 : row_new;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    req_d       = req_q;
    bkt_d       = bkt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    hash_start  = 1'b0;
    ram_re      = 1'b0;

    // A result leaves the output register when the consumer takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + BW'(1);
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          if (in_data_i.key == '0) begin
            res_d.status    = ST_ZERO_KEY;
            res_d.entry_out = '0;
            state_d         = S_PUSH;
          end else begin
            hash_start = 1'b1;
            state_d    = S_HASH;
          end
        end
      end
      S_HASH: begin
        // The row read is issued in the cycle the bucket index is ready.
        if (hash_done) begin
          bkt_d   = hash_bucket;
          ram_re  = 1'b1;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        res_d.status    = upd.status;
        res_d.entry_out = upd.entry;
        state_d         = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      req_q       <= '0;
      bkt_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      req_q       <= req_d;
      bkt_q       <= bkt_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- design/hkt_checker.sv -----
// ----------------------------------------------------------------------------
// hkt_checker: port-level checks of the hashed key take table
// Watches both channels and tracks how many items are in flight.
// ----------------------------------------------------------------------------
module hkt_checker import hkt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input out_t out_data_i
);

  logic       in_acc, out_acc;
  logic [1:0] cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // Only a successful take carries a payload.
  a_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != ST_OK) |-> out_data_i.entry_out == '0)
    else $error("nonzero payload on a failed operation");

  // Items are worked on one at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input taken while an item is in work");

  // No result without an item behind it.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> cnt_q != 2'd0)
    else $error("result without a pending item");

  // At most one item in work and one result waiting.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("too many items in flight");

endmodule

bind hashed_key_take_table hkt_checker u_hkt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_i (out_data_o)
);
